### rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
`default_nettype none

package bba_pkg;

  localparam int NUM_LEVELS_DEF = 10;
  localparam int MEM_BYTES_DEF  = 1024;
  localparam int LIST_DEPTH_DEF = 512;

  // Fixed widths of the request and result words.
  localparam int REQ_W = 11;
  localparam int OUT_W = 10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_RD_FIRST,
    S_RD_LAST,
    S_TAKE_WR,
    S_APP_LO,
    S_APP_HI,
    S_GRANT,
    S_REFUSE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SEARCH,
    DP_RD_FIRST,
    DP_RD_LAST,
    DP_TAKE_WR,
    DP_APP_LO,
    DP_APP_HI,
    DP_GRANT,
    DP_REFUSE
  } dp_op_t;

  typedef struct packed {
    logic found;      // a non-empty list of sufficient size exists
    logic at_target;  // current level equals the requested level
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bba_ctrl.sv
// Control state machine that sequences the allocator datapath.
`default_nettype none

module bba_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bba_pkg::dp_op_t          op,
  input  wire bba_pkg::dp_status_t status
);

  bba_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::S_IDLE:     if (in_valid) state_nxt = bba_pkg::S_SEARCH;
      bba_pkg::S_SEARCH: begin
        state_nxt = status.found ? bba_pkg::S_RD_FIRST : bba_pkg::S_REFUSE;
      end
      bba_pkg::S_RD_FIRST: state_nxt = bba_pkg::S_RD_LAST;
      bba_pkg::S_RD_LAST:  state_nxt = bba_pkg::S_TAKE_WR;
      bba_pkg::S_TAKE_WR: begin
        state_nxt = status.at_target ? bba_pkg::S_GRANT : bba_pkg::S_APP_LO;
      end
      bba_pkg::S_APP_LO:   state_nxt = bba_pkg::S_APP_HI;
      bba_pkg::S_APP_HI:   state_nxt = bba_pkg::S_RD_FIRST;
      bba_pkg::S_GRANT:    if (out_free) state_nxt = bba_pkg::S_IDLE;
      bba_pkg::S_REFUSE:   if (out_free) state_nxt = bba_pkg::S_IDLE;
      default:             state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op            = bba_pkg::DP_NOP;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      bba_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = bba_pkg::DP_LOAD;
      end
      bba_pkg::S_SEARCH:   op = bba_pkg::DP_SEARCH;
      bba_pkg::S_RD_FIRST: op = bba_pkg::DP_RD_FIRST;
      bba_pkg::S_RD_LAST:  op = bba_pkg::DP_RD_LAST;
      bba_pkg::S_TAKE_WR:  op = bba_pkg::DP_TAKE_WR;
      bba_pkg::S_APP_LO:   op = bba_pkg::DP_APP_LO;
      bba_pkg::S_APP_HI:   op = bba_pkg::DP_APP_HI;
      bba_pkg::S_GRANT: begin
        if (out_free) begin
          op            = bba_pkg::DP_GRANT;
          out_valid_nxt = 1'b1;
        end
      end
      bba_pkg::S_REFUSE: begin
        if (out_free) begin
          op            = bba_pkg::DP_REFUSE;
          out_valid_nxt = 1'b1;
        end
      end
      default: op = bba_pkg::DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bba_datapath.sv
// Free-list storage, level search and block arithmetic of the allocator.
`default_nettype none

module bba_datapath #(
  parameter int NUM_LEVELS = bba_pkg::NUM_LEVELS_DEF,
  parameter int MEM_BYTES  = bba_pkg::MEM_BYTES_DEF,
  parameter int LIST_DEPTH = bba_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bba_pkg::dp_op_t           op,
  output bba_pkg::dp_status_t            status,
  input  wire logic [bba_pkg::REQ_W-1:0] in_req_size,
  output logic                           out_granted,
  output logic      [bba_pkg::OUT_W-1:0] out_block_start,
  output logic      [bba_pkg::OUT_W-1:0] out_block_end
);

  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int IW    = $clog2(LIST_DEPTH);
  localparam int SW    = $clog2(MEM_BYTES);
  localparam int DEPTH = NUM_LEVELS * LIST_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = ((SW > bba_pkg::OUT_W) ? SW : bba_pkg::OUT_W) + NUM_LEVELS + 1;
  localparam int SZW   = bba_pkg::REQ_W + NUM_LEVELS + 1;
  localparam logic [SW-1:0] MASK = SW'(MEM_BYTES - 1);
  localparam logic [AW-1:0] TOP0 = AW'((NUM_LEVELS - 1) * LIST_DEPTH);

  logic [bba_pkg::REQ_W-1:0] sz_r;
  logic [LW-1:0]             n_r, lvl_r;
  logic [SW-1:0]             start_r;
  logic [CW-1:0]             cnt_r [NUM_LEVELS];
  logic                      top_fresh_r, rd_top_r;
  logic                      granted_r;
  logic [bba_pkg::OUT_W-1:0] bstart_r, bend_r;

  logic [NUM_LEVELS-1:0] fits, usable;
  logic [LW-1:0]         n_c, i_c, cur_lvl;
  logic                  size_ok;
  logic [CW-1:0]         cnt_cur, last_cnt;
  logic                  app_ok;
  logic [AW-1:0]         base, raddr, waddr;
  logic                  we;
  logic [SW-1:0]         wdata, rdata, rdata_eff, hi_start;
  logic [SUMW-1:0]       half, size_n, start_ext, end_sum;

  // Level k holds blocks of 2^(k+1) bytes; a nonzero request of at most
  // MEM_BYTES fits every level whose block is at least the requested size.
  assign size_ok = (sz_r != '0) && (32'(sz_r) <= 32'(MEM_BYTES));

  always_comb begin
    for (int k = 0; k < NUM_LEVELS; k++) begin
      fits[k]   = size_ok && ((SZW'(1) << (k + 1)) >= SZW'(sz_r));
      usable[k] = fits[k] && (cnt_r[k] != '0);
    end
    n_c = '0;
    i_c = '0;
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (fits[k])   n_c = LW'(k);
      if (usable[k]) i_c = LW'(k);
    end
  end

  assign status.found     = |usable;
  assign status.at_target = (lvl_r == n_r);

  assign cur_lvl  = (op == bba_pkg::DP_APP_LO) ? (lvl_r - LW'(1)) : lvl_r;
  assign cnt_cur  = cnt_r[cur_lvl];
  assign last_cnt = cnt_cur - CW'(1);
  assign app_ok   = cnt_cur < CW'(LIST_DEPTH);
  assign base     = AW'(cur_lvl) * AW'(LIST_DEPTH);

  // After reset the top list's first slot holds block zero without a write.
  assign rdata_eff = (rd_top_r && top_fresh_r) ? '0 : rdata;

  assign half      = SUMW'(1) << (32'(lvl_r) + 1);
  assign hi_start  = SW'(SUMW'(start_r) + half) & MASK;
  assign size_n    = SUMW'(1) << (32'(n_r) + 1);
  assign start_ext = SUMW'(start_r);
  assign end_sum   = start_ext + size_n - SUMW'(1);

  always_comb begin
    we    = 1'b0;
    raddr = base;
    waddr = base;
    wdata = start_r;
    unique case (op)
      bba_pkg::DP_RD_LAST: raddr = base + AW'(last_cnt[IW-1:0]);
      bba_pkg::DP_TAKE_WR: begin
        we    = 1'b1;
        wdata = rdata_eff;
      end
      bba_pkg::DP_APP_LO: begin
        we    = app_ok;
        waddr = base + AW'(cnt_cur[IW-1:0]);
        wdata = start_r & MASK;
      end
      bba_pkg::DP_APP_HI: begin
        we    = app_ok;
        waddr = base + AW'(cnt_cur[IW-1:0]);
        wdata = hi_start;
      end
      default: we = 1'b0;
    endcase
  end

  bba_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_list_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        cnt_r[k] <= (k == NUM_LEVELS - 1) ? CW'(1) : '0;
      end
      top_fresh_r <= 1'b1;
    end else begin
      case (op) inside
        bba_pkg::DP_TAKE_WR: cnt_r[cur_lvl] <= last_cnt;
        bba_pkg::DP_APP_LO,
        bba_pkg::DP_APP_HI: if (app_ok) cnt_r[cur_lvl] <= cnt_cur + CW'(1);
        default: ;
      endcase
      if (we && (waddr == TOP0)) top_fresh_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_top_r <= (raddr == TOP0);
    case (op)
      bba_pkg::DP_LOAD: sz_r <= in_req_size;
      bba_pkg::DP_SEARCH: begin
        n_r   <= n_c;
        lvl_r <= i_c;
      end
      bba_pkg::DP_RD_LAST: start_r <= rdata_eff;
      bba_pkg::DP_APP_LO:  lvl_r <= cur_lvl;
      bba_pkg::DP_GRANT: begin
        granted_r <= 1'b1;
        bstart_r  <= start_ext[bba_pkg::OUT_W-1:0];
        bend_r    <= end_sum[bba_pkg::OUT_W-1:0];
      end
      bba_pkg::DP_REFUSE: begin
        granted_r <= 1'b0;
        bstart_r  <= '0;
        bend_r    <= '0;
      end
      default: ;
    endcase
  end

  assign out_granted     = granted_r;
  assign out_block_start = bstart_r;
  assign out_block_end   = bend_r;

endmodule

`default_nettype wire

### rtl/buddy_block_allocator.sv
// Top level of the allocation-only buddy block allocator.
`default_nettype none

// Allocation-only buddy allocator over a MEM_BYTES region. Level L keeps a
// free list of blocks of 2^(L+1) bytes, LIST_DEPTH slots per level, held in
// one block RAM of NUM_LEVELS * LIST_DEPTH entries; only the per-level
// counts live in flip-flops. After reset the whole region is one free block
// at the top level, and no clearing pass is needed. Each request word gives
// a size in bytes, rounded up to a power of two with a minimum of two. The
// allocator picks the smallest non-empty level that fits, removes that
// list's first entry (the last entry moves into its slot), and splits the
// block down to the requested level, appending the lower and then the upper
// half at each level and again removing the first entry. The result word
// carries the granted flag and the first and last byte of the block; a zero
// or oversized request, or one that no free block can hold, returns a
// refusal with both addresses zero and leaves the lists unchanged. Items
// are handled one at a time. A granted request passes in order through the
// level search, a removal from the chosen list (two reads of the single RAM
// read port and a write back), and for each split a pair of appends and
// another removal, before the output register is loaded; there are 0 to
// NUM_LEVELS-1 splits. A refused request skips the list work: the level
// search is followed by loading the output register. A finished result
// that finds the previous one still held in the output register waits
// until that one is taken. The next request is accepted the cycle after
// the result is loaded, even if the result has not yet been taken; a
// result waits in the output register while out_stall holds.
module buddy_block_allocator #(
  parameter int NUM_LEVELS = bba_pkg::NUM_LEVELS_DEF,
  parameter int MEM_BYTES  = bba_pkg::MEM_BYTES_DEF,
  parameter int LIST_DEPTH = bba_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [bba_pkg::REQ_W-1:0] in_req_size,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_granted,
  output logic      [bba_pkg::OUT_W-1:0] out_block_start,
  output logic      [bba_pkg::OUT_W-1:0] out_block_end
);

  // The controller only issues one datapath operation per cycle and reads
  // back whether a fitting block exists and whether splitting is done.
  bba_pkg::dp_op_t     op;
  bba_pkg::dp_status_t status;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .op       (op),
    .status   (status)
  );

  bba_datapath #(
    .NUM_LEVELS(NUM_LEVELS),
    .MEM_BYTES (MEM_BYTES),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .in_req_size    (in_req_size),
    .out_granted    (out_granted),
    .out_block_start(out_block_start),
    .out_block_end  (out_block_end)
  );

endmodule

`default_nettype wire
